// File: design/tmhq_pkg.sv
// Shared types, codes and constants of the task min-heap queue.
package tmhq_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int COUNT_OUT_W  = 11;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [31:0] pri;
        logic [63:0] name;
    } entry_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] code;
        logic       ins_start;
        logic       pop_read;
        logic       pop_load;
        logic       wr_new;
        logic       up_read;
        logic       up_move;
        logic       dn_read;
        logic       dn_move;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic one_left;
        logic at_root;
        logic leaf;
        logic up_less;
        logic dn_less;
    } stat_t;

    // Lower priority first, then lower name: one unsigned compare of the packed pair.
    function automatic logic entry_before(input entry_t a, input entry_t b);
        entry_before = (a < b);
    endfunction

endpackage

// File: design/tmhq_ctrl.sv
// Controller state machine of the task min-heap queue.
module tmhq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            action,
    input  tmhq_pkg::stat_t stat,
    output tmhq_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_POP_LD,
        S_DN_CHK,
        S_DN_CMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        cmd.code   = tmhq_pkg::ST_OK;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    if (action == tmhq_pkg::ACT_INSERT)
                    begin
                        if (stat.full)
                        begin
                            cmd.code  = tmhq_pkg::ST_FULL;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            cmd.ins_start = 1'b1;
                            state_next    = S_UP_CHK;
                        end
                    end
                    else
                    begin
                        if (stat.empty)
                        begin
                            cmd.code  = tmhq_pkg::ST_EMPTY;
                            done_next = 1'b1;
                        end
                        else
                        begin
                            cmd.pop_read = 1'b1;
                            state_next   = S_POP_LD;
                        end
                    end
                end
            end
            S_UP_CHK:
            begin
                if (stat.at_root)
                begin
                    cmd.wr_new = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.up_read = 1'b1;
                    state_next  = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (stat.up_less)
                begin
                    cmd.up_move = 1'b1;
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_POP_LD:
            begin
                cmd.pop_load = 1'b1;
                if (stat.one_left)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DN_CHK;
                end
            end
            S_DN_CHK:
            begin
                if (stat.leaf)
                begin
                    cmd.wr_new = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.dn_read = 1'b1;
                    state_next  = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (stat.dn_less)
                begin
                    cmd.dn_move = 1'b1;
                    state_next  = S_DN_CHK;
                end
                else
                begin
                    cmd.wr_new = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// File: design/tmhq_dpath.sv
// Datapath of the task min-heap queue: heap memory, count, hole position and result registers.
module tmhq_dpath
#(
    parameter int CAPACITY = tmhq_pkg::DEF_CAPACITY
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmhq_pkg::cmd_t                    cmd,
    input  logic [31:0]                       task_priority,
    input  logic [63:0]                       task_name,
    output tmhq_pkg::stat_t                   stat,
    output logic [31:0]                       out_priority,
    output logic [63:0]                       out_name,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic [tmhq_pkg::COUNT_OUT_W-1:0]  entry_count,
    output logic                              is_empty
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CH_W  = IDX_W + 1;

    tmhq_pkg::entry_t heap_mem [CAPACITY];

    tmhq_pkg::entry_t rd_a_reg;
    tmhq_pkg::entry_t rd_b_reg;
    tmhq_pkg::entry_t new_reg;
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] pos_reg;
    logic [31:0]      out_pri_reg;
    logic [63:0]      out_name_reg;
    logic             out_valid_reg;
    logic [1:0]       status_reg;

    logic [IDX_W-1:0] parent_idx;
    logic [CH_W-1:0]  left_idx;
    logic [CH_W-1:0]  right_idx;
    logic [CH_W-1:0]  count_ext;
    logic             right_ok;
    logic             pick_right;
    tmhq_pkg::entry_t pick_ent;
    logic [IDX_W-1:0] pick_idx;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic             wr_en;
    tmhq_pkg::entry_t wr_data;

    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = left_idx + CH_W'(1);
    assign count_ext  = CH_W'(count_reg);
    assign right_ok   = (right_idx < count_ext);
    assign pick_right = right_ok && tmhq_pkg::entry_before(rd_b_reg, rd_a_reg);
    assign pick_ent   = pick_right ? rd_b_reg : rd_a_reg;
    assign pick_idx   = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];

    always_comb
    begin
        stat.full     = (count_reg == CNT_W'(CAPACITY));
        stat.empty    = (count_reg == '0);
        stat.one_left = (count_reg == CNT_W'(1));
        stat.at_root  = (pos_reg == '0);
        stat.leaf     = (left_idx >= count_ext);
        stat.up_less  = tmhq_pkg::entry_before(new_reg, rd_a_reg);
        stat.dn_less  = pick_right ? tmhq_pkg::entry_before(rd_b_reg, new_reg)
                                   : tmhq_pkg::entry_before(rd_a_reg, new_reg);
    end

    always_comb
    begin
        if (cmd.dn_read)
        begin
            rd_addr_a = left_idx[IDX_W-1:0];
        end
        else if (cmd.up_read)
        begin
            rd_addr_a = parent_idx;
        end
        else
        begin
            rd_addr_a = '0;
        end
        if (cmd.pop_read)
        begin
            rd_addr_b = IDX_W'(count_reg - CNT_W'(1));
        end
        else
        begin
            rd_addr_b = right_idx[IDX_W-1:0];
        end
    end

    assign wr_en = cmd.wr_new | cmd.up_move | cmd.dn_move;

    always_comb
    begin
        if (cmd.up_move)
        begin
            wr_data = rd_a_reg;
        end
        else if (cmd.dn_move)
        begin
            wr_data = pick_ent;
        end
        else
        begin
            wr_data = new_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[pos_reg] <= wr_data;
        end
        rd_a_reg <= heap_mem[rd_addr_a];
        rd_b_reg <= heap_mem[rd_addr_b];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            new_reg.pri  <= task_priority;
            new_reg.name <= task_name;
        end
        else if (cmd.pop_load)
        begin
            new_reg <= rd_b_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            out_pri_reg   <= '0;
            out_name_reg  <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= tmhq_pkg::ST_OK;
        end
        else
        begin
            if (cmd.accept)
            begin
                out_pri_reg   <= '0;
                out_name_reg  <= '0;
                out_valid_reg <= 1'b0;
                status_reg    <= cmd.code;
            end
            if (cmd.ins_start)
            begin
                pos_reg   <= IDX_W'(count_reg);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.pop_load)
            begin
                out_pri_reg   <= rd_a_reg.pri;
                out_name_reg  <= rd_a_reg.name;
                out_valid_reg <= 1'b1;
                count_reg     <= count_reg - CNT_W'(1);
                pos_reg       <= '0;
            end
            if (cmd.up_move)
            begin
                pos_reg <= parent_idx;
            end
            if (cmd.dn_move)
            begin
                pos_reg <= pick_idx;
            end
        end
    end

    assign out_priority = out_pri_reg;
    assign out_name     = out_name_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_count  = tmhq_pkg::COUNT_OUT_W'(count_reg);
    assign is_empty     = (count_reg == '0);

endmodule

// File: design/task_min_heap_queue.sv
// Top level of the task min-heap queue: controller, datapath and checks.
//
// A request is taken when start is high and busy is low. Its result appears
// for one cycle with done high and cannot be held off. The heap lives in a
// single memory with one write port and two registered read ports, and the
// sift walks it one level at a time (read, then compare and write). A refused
// insert or a pop on an empty heap returns done in the cycle after the
// request. An insert climbs level by level until it stops or reaches the
// root; a pop descends level by level until it stops or reaches a leaf, and
// skips the descent when it removes the last task. busy is low again in the
// done cycle, so the next request can be taken at that edge. The heap memory
// is never cleared.
module task_min_heap_queue
#(
    parameter int CAPACITY = tmhq_pkg::DEF_CAPACITY
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [31:0]                       task_priority,
    input  logic [63:0]                       task_name,
    output logic                              done,
    output logic [31:0]                       out_priority,
    output logic [63:0]                       out_name,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic [tmhq_pkg::COUNT_OUT_W-1:0]  entry_count,
    output logic                              is_empty
);

    tmhq_pkg::cmd_t  cmd;
    tmhq_pkg::stat_t stat;

    tmhq_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tmhq_dpath
    #(
        .CAPACITY (CAPACITY)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .task_priority (task_priority),
        .task_name     (task_name),
        .stat          (stat),
        .out_priority  (out_priority),
        .out_name      (out_name),
        .out_valid     (out_valid),
        .status        (status),
        .entry_count   (entry_count),
        .is_empty      (is_empty)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("request taken with no work and no result");

    a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && out_valid) |-> (status == tmhq_pkg::ST_OK))
        else $error("popped task reported with error status");

    a_refused_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != tmhq_pkg::ST_OK)) |-> (!out_valid && (out_name == '0)))
        else $error("refused request returned a task");

endmodule
